[src/mmc1_pkg.sv]
// Shared types and constants of the serial-load bank mapper.
// Used by mmc1_bank_mapper; depends on nothing else.
package mmc1_pkg;

   typedef enum logic [1:0] {
      CMD_CPU_READ  = 2'd0,
      CMD_CPU_WRITE = 2'd1,
      CMD_PPU_READ  = 2'd2,
      CMD_PPU_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_WRAM = 2'd1,
      KIND_PRG  = 2'd2,
      KIND_CHR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SEL_CONTROL  = 2'd0,
      SEL_CHR_LOW  = 2'd1,
      SEL_CHR_HIGH = 2'd2,
      SEL_PRG_BANK = 2'd3
   } reg_sel_type;

   typedef enum logic [1:0] {
      CSR_PRG_BANK_COUNT = 2'd0,
      CSR_CHR_SIZE_4K    = 2'd1,
      CSR_UNUSED_2       = 2'd2,
      CSR_UNUSED_3       = 2'd3
   } csr_index_type;

   localparam logic [1:0]  PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0]  PRG_MODE_FIX_LAST  = 2'd3;

   localparam logic [4:0]  SHIFT_MARK     = 5'b10000;
   localparam logic [4:0]  PRG_MODE3_BITS = 5'b01100;
   localparam logic [15:0] WRAM_BASE      = 16'h6000;
   localparam logic [15:0] PRG_BASE       = 16'h8000;
   localparam logic [15:0] CHR_LIMIT      = 16'h2000;
   localparam logic [4:0]  PRG_COUNT_RST  = 5'd2;
   localparam logic [5:0]  CHR_SIZE_RST   = 6'd2;

endpackage

[src/mmc1_bank_mapper.sv]
// Serial-load bank mapper: register file, address translation and work RAM.
// Depends on mmc1_pkg for command, kind and register codes.
//
// Usage:
//  req_* carries one bus access per item: tuser is the command, tdata the
//  address and write byte. rsp_* returns exactly one result item per access:
//  tuser is the result kind, tdata the read byte, mapped offset, CHR range
//  and write flags and the mirror mode. csr_* writes the PRG bank count and
//  the CHR size at any edge where csr_wr_en is high.
//  The result appears the cycle after the item is accepted, and one item can
//  be accepted every cycle while rsp_tready is high. The work RAM is a single
//  synchronous memory; a write is visible to the read of the next item.
//  After reset the work RAM is zeroed by a sweep of all WORK_RAM_BYTES bytes
//  (8192 by default), one byte per cycle; req_tready stays low meanwhile.
//  If rsp_tready is low while a result waits, the result register holds and
//  req_tready drops until the result is taken.
module mmc1_bank_mapper #(
   parameter int WORK_RAM_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], write_data[23:16]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_data[7:0], mapped_address[25:8],
                                    // chr_in_range[26], chr_write[27],
                                    // mirror_mode[29:28], zero[31:30]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int RamAw = $clog2(WORK_RAM_BYTES);

   logic [7:0]            ram_mem [WORK_RAM_BYTES];
   logic [7:0]            ram_rd_ff;
   logic                  ram_we;
   logic [RamAw-1:0]      ram_wa;
   logic [7:0]            ram_wd;

   logic                  clearing_ff;
   logic [RamAw-1:0]      clr_idx_ff;

   logic [4:0]            prg_count_ff;
   logic [5:0]            chr_size_ff;

   logic [4:0]            shift_ff, shift_in;
   logic [4:0]            control_ff, control_in;
   logic [4:0]            chr_low_ff, chr_low_in;
   logic [4:0]            chr_high_ff, chr_high_in;
   logic [4:0]            prg_bank_ff, prg_bank_in;

   logic                  valid_ff;
   mmc1_pkg::kind_type    kind_ff, kind_in;
   logic                  ram_sel_ff, ram_sel_in;
   logic [17:0]           mapped_ff, mapped_in;
   logic                  in_range_ff, in_range_in;
   logic                  chr_write_ff, chr_write_in;
   logic [1:0]            mirror_ff;

   mmc1_pkg::cmd_type     cmd;
   logic [15:0]           addr;
   logic [7:0]            wdata;
   logic                  accept;
   logic                  is_cpu;
   logic                  ram_hit;
   logic                  prg_hit;
   logic                  chr_hit;
   logic                  reg_write;
   logic [15:0]           ram_off;
   logic [RamAw-1:0]      ram_idx;
   logic [3:0]            prg_sel;
   logic [3:0]            prg_last;
   logic [17:0]           prg_off;
   logic [4:0]            chr_bank;
   logic [17:0]           chr_off;
   logic [17:0]           chr_lim;
   logic [4:0]            shift_next;

   assign cmd    = mmc1_pkg::cmd_type'(req_tuser);
   assign addr   = req_tdata[15:0];
   assign wdata  = req_tdata[23:16];

   assign req_tready = !clearing_ff && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_cpu  = (cmd == mmc1_pkg::CMD_CPU_READ) || (cmd == mmc1_pkg::CMD_CPU_WRITE);
   assign ram_hit = is_cpu && (addr >= mmc1_pkg::WRAM_BASE) && (addr < mmc1_pkg::PRG_BASE);
   assign prg_hit = is_cpu && (addr >= mmc1_pkg::PRG_BASE);
   assign chr_hit = !is_cpu && (addr < mmc1_pkg::CHR_LIMIT);
   assign reg_write = prg_hit && (cmd == mmc1_pkg::CMD_CPU_WRITE);

   assign ram_off = addr - mmc1_pkg::WRAM_BASE;
   assign ram_idx = ram_off[RamAw-1:0];

   // PRG translation
   always_comb begin
      prg_last = prg_count_ff[3:0] - 4'd1;
      prg_sel  = prg_bank_ff[3:0];
      case (control_ff[3:2])
         mmc1_pkg::PRG_MODE_FIX_FIRST: prg_sel = addr[14] ? prg_bank_ff[3:0] : 4'd0;
         mmc1_pkg::PRG_MODE_FIX_LAST:  prg_sel = addr[14] ? prg_last : prg_bank_ff[3:0];
         default:                      prg_sel = prg_bank_ff[3:0];
      endcase
      if (!control_ff[3]) begin
         prg_off = {prg_bank_ff[3:1], addr[14:0]};
      end else begin
         prg_off = {prg_sel, addr[13:0]};
      end
   end

   // CHR translation
   always_comb begin
      chr_bank = addr[12] ? chr_high_ff : chr_low_ff;
      if (!control_ff[4]) begin
         chr_off = {1'b0, chr_low_ff[4:1], addr[12:0]};
      end else begin
         chr_off = {1'b0, chr_bank, addr[11:0]};
      end
      chr_lim = {chr_size_ff, 12'h000};
   end

   // serial register load
   always_comb begin
      shift_in    = shift_ff;
      control_in  = control_ff;
      chr_low_in  = chr_low_ff;
      chr_high_in = chr_high_ff;
      prg_bank_in = prg_bank_ff;
      shift_next  = {wdata[0], shift_ff[4:1]};
      if (accept && reg_write) begin
         if (wdata[7]) begin
            shift_in   = mmc1_pkg::SHIFT_MARK;
            control_in = control_ff | mmc1_pkg::PRG_MODE3_BITS;
         end else if (shift_ff[0]) begin
            shift_in = mmc1_pkg::SHIFT_MARK;
            case (mmc1_pkg::reg_sel_type'(addr[14:13]))
               mmc1_pkg::SEL_CONTROL:  control_in  = shift_next;
               mmc1_pkg::SEL_CHR_LOW:  chr_low_in  = shift_next;
               mmc1_pkg::SEL_CHR_HIGH: chr_high_in = shift_next;
               default:                prg_bank_in = shift_next;
            endcase
         end else begin
            shift_in = shift_next;
         end
      end
   end

   // result fields
   always_comb begin
      kind_in      = mmc1_pkg::KIND_NONE;
      ram_sel_in   = 1'b0;
      mapped_in    = {2'b00, addr};
      in_range_in  = 1'b0;
      chr_write_in = 1'b0;
      if (ram_hit) begin
         kind_in    = mmc1_pkg::KIND_WRAM;
         ram_sel_in = (cmd == mmc1_pkg::CMD_CPU_READ);
         mapped_in  = 18'(ram_idx);
      end else if (prg_hit && (cmd == mmc1_pkg::CMD_CPU_READ)) begin
         kind_in   = mmc1_pkg::KIND_PRG;
         mapped_in = prg_off;
      end else if (chr_hit) begin
         kind_in      = mmc1_pkg::KIND_CHR;
         mapped_in    = chr_off;
         in_range_in  = (chr_off < chr_lim);
         chr_write_in = (cmd == mmc1_pkg::CMD_PPU_WRITE) && (chr_off < chr_lim);
      end
   end

   // work RAM port: sweep after reset, then item writes
   always_comb begin
      ram_we = 1'b0;
      ram_wa = ram_idx;
      ram_wd = wdata;
      if (clearing_ff) begin
         ram_we = 1'b1;
         ram_wa = clr_idx_ff;
         ram_wd = 8'h00;
      end else if (accept && ram_hit && (cmd == mmc1_pkg::CMD_CPU_WRITE)) begin
         ram_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_wa] <= ram_wd;
      end
      if (accept) begin
         ram_rd_ff <= ram_mem[ram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         valid_ff     <= 1'b0;
         prg_count_ff <= mmc1_pkg::PRG_COUNT_RST;
         chr_size_ff  <= mmc1_pkg::CHR_SIZE_RST;
         shift_ff     <= mmc1_pkg::SHIFT_MARK;
         control_ff   <= mmc1_pkg::PRG_MODE3_BITS;
         chr_low_ff   <= '0;
         chr_high_ff  <= '0;
         prg_bank_ff  <= '0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == RamAw'(WORK_RAM_BYTES - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (mmc1_pkg::csr_index_type'(csr_index))
               mmc1_pkg::CSR_PRG_BANK_COUNT: prg_count_ff <= csr_wdata[4:0];
               mmc1_pkg::CSR_CHR_SIZE_4K:    chr_size_ff  <= csr_wdata;
               default: ;
            endcase
         end
         shift_ff    <= shift_in;
         control_ff  <= control_in;
         chr_low_ff  <= chr_low_in;
         chr_high_ff <= chr_high_in;
         prg_bank_ff <= prg_bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= kind_in;
         ram_sel_ff   <= ram_sel_in;
         mapped_ff    <= mapped_in;
         in_range_ff  <= in_range_in;
         chr_write_ff <= chr_write_in;
         mirror_ff    <= control_in[1:0];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {2'b00, mirror_ff, chr_write_ff, in_range_ff, mapped_ff,
                        (ram_sel_ff ? ram_rd_ff : 8'h00)};

endmodule

[tb/mmc1_bank_mapper_tb.sv]
// Self-checking testbench for mmc1_bank_mapper: drives bus accesses and CSR writes,
// predicts every result item with its own shadow of the mapper state.
// Depends on mmc1_pkg and the mmc1_bank_mapper RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int        IDLE_LIMIT   = 50000;
   localparam int        PHASES       = 5;
   localparam int        PHASE_ITEMS  = 170;

   typedef struct {
      mmc1_pkg::kind_type kind;
      logic [7:0]         rdata;
      logic [17:0]        mapped;
      logic               in_range;
      logic               chr_wr;
      logic [1:0]         mirror;
   } access_result_type;

   class bank_map_shadow;
      logic [4:0]        shift_reg;
      logic [4:0]        ctrl;
      logic [4:0]        chr_lo;
      logic [4:0]        chr_hi;
      logic [4:0]        prg_sel;
      logic [4:0]        prg_count;
      logic [5:0]        chr_size;
      logic [7:0]        wram [8192];
      access_result_type due_results [$];
      int                errors;
      int                checked;

      function new();
         shift_reg = mmc1_pkg::SHIFT_MARK;
         ctrl      = mmc1_pkg::PRG_MODE3_BITS;
         chr_lo    = '0;
         chr_hi    = '0;
         prg_sel   = '0;
         prg_count = mmc1_pkg::PRG_COUNT_RST;
         chr_size  = mmc1_pkg::CHR_SIZE_RST;
         foreach (wram[i]) wram[i] = 8'h00;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_config(mmc1_pkg::csr_index_type idx, logic [5:0] value);
         case (idx)
            mmc1_pkg::CSR_PRG_BANK_COUNT: prg_count = value[4:0];
            mmc1_pkg::CSR_CHR_SIZE_4K:    chr_size  = value;
            default: ;
         endcase
      endfunction

      function logic [17:0] prg_offset(logic [15:0] a);
         logic [3:0] bank;
         logic [3:0] last;
         logic [1:0] mode;
         logic [3:0] sel;
         bank = prg_sel[3:0];
         last = prg_count[3:0] - 4'd1;
         mode = ctrl[3:2];
         if (!mode[1]) return {bank[3:1], a[14:0]};
         if (mode == mmc1_pkg::PRG_MODE_FIX_FIRST) sel = a[14] ? bank : 4'd0;
         else sel = a[14] ? last : bank;
         return {sel, a[13:0]};
      endfunction

      function logic [17:0] chr_offset(logic [15:0] a);
         if (!ctrl[4]) return {1'b0, chr_lo[4:1], a[12:0]};
         if (!a[12]) return {1'b0, chr_lo, a[11:0]};
         return {1'b0, chr_hi, a[11:0]};
      endfunction

      function void shift_in(logic [15:0] a, logic [7:0] d);
         logic full;
         if (d[7]) begin
            shift_reg = mmc1_pkg::SHIFT_MARK;
            ctrl = ctrl | mmc1_pkg::PRG_MODE3_BITS;
            return;
         end
         full = shift_reg[0];
         shift_reg = {d[0], shift_reg[4:1]};
         if (!full) return;
         case (mmc1_pkg::reg_sel_type'(a[14:13]))
            mmc1_pkg::SEL_CONTROL:  ctrl    = shift_reg;
            mmc1_pkg::SEL_CHR_LOW:  chr_lo  = shift_reg;
            mmc1_pkg::SEL_CHR_HIGH: chr_hi  = shift_reg;
            default:                prg_sel = shift_reg;
         endcase
         shift_reg = mmc1_pkg::SHIFT_MARK;
      endfunction

      function void note_access(mmc1_pkg::cmd_type cmd, logic [15:0] a, logic [7:0] d);
         access_result_type r;
         r.kind     = mmc1_pkg::KIND_NONE;
         r.rdata    = 8'h00;
         r.mapped   = {2'b00, a};
         r.in_range = 1'b0;
         r.chr_wr   = 1'b0;
         if (cmd == mmc1_pkg::CMD_CPU_READ || cmd == mmc1_pkg::CMD_CPU_WRITE) begin
            if (a >= mmc1_pkg::WRAM_BASE && a < mmc1_pkg::PRG_BASE) begin
               r.kind   = mmc1_pkg::KIND_WRAM;
               r.mapped = {5'd0, a[12:0]};
               if (cmd == mmc1_pkg::CMD_CPU_READ) r.rdata = wram[a[12:0]];
               else wram[a[12:0]] = d;
            end else if (a >= mmc1_pkg::PRG_BASE) begin
               if (cmd == mmc1_pkg::CMD_CPU_READ) begin
                  r.kind   = mmc1_pkg::KIND_PRG;
                  r.mapped = prg_offset(a);
               end else begin
                  shift_in(a, d);
               end
            end
         end else if (a < mmc1_pkg::CHR_LIMIT) begin
            r.kind     = mmc1_pkg::KIND_CHR;
            r.mapped   = chr_offset(a);
            r.in_range = int'(r.mapped) < int'(chr_size) * 4096;
            r.chr_wr   = (cmd == mmc1_pkg::CMD_PPU_WRITE) && r.in_range;
         end
         r.mirror = ctrl[1:0];
         due_results.push_back(r);
      endfunction

      function void check_result(logic [1:0] kind, logic [31:0] data);
         access_result_type e;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("error: result item with no access pending");
            return;
         end
         e = due_results.pop_front();
         checked++;
         if (kind !== e.kind || data[7:0] !== e.rdata || data[25:8] !== e.mapped ||
             data[26] !== e.in_range || data[27] !== e.chr_wr ||
             data[29:28] !== e.mirror || data[31:30] !== 2'b00) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp kind %0d rd %02h map %05h rng %0b wr %0b mir %0d",
                        e.kind, e.rdata, e.mapped, e.in_range, e.chr_wr, e.mirror,
                        " | got kind %0d rd %02h map %05h rng %0b wr %0b mir %0d pad %0b",
                        kind, data[7:0], data[25:8], data[26], data[27], data[29:28],
                        data[31:30]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // address[15:0], write_data[23:16]
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // read_data[7:0], mapped_address[25:8], chr_in_range[26],
                                  // chr_write[27], mirror_mode[29:28], zero[31:30]
   logic [1:0]  rsp_tuser;        // kind[1:0]
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_wdata = '0;

   bank_map_shadow shadow = new();
   bit             gaps_on = 1'b1;
   int             items_sent = 0;
   int             settings = 0;
   int             idle_cycles = 0;

   mmc1_bank_mapper uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            shadow.note_access(mmc1_pkg::cmd_type'(req_tuser), req_tdata[15:0],
                               req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready) shadow.check_result(rsp_tuser, rsp_tdata);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL mmc1_bank_mapper");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int gap;
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_access(mmc1_pkg::cmd_type cmd, logic [15:0] a, logic [7:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {d, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (shadow.due_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(mmc1_pkg::csr_index_type idx, logic [5:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      shadow.set_config(idx, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_register(mmc1_pkg::reg_sel_type sel, logic [4:0] value, bit noisy);
      int break_at;
      break_at = noisy ? $urandom_range(0, 4) : 5;
      for (int i = 0; i < 5; i++) begin
         if (i == break_at)
            send_access(mmc1_pkg::CMD_CPU_WRITE, {1'b1, 15'($urandom)},
                        {1'b1, 7'($urandom)});
         if ($urandom_range(0, 99) < 15)
            send_access(mmc1_pkg::CMD_PPU_READ, {3'b000, 13'($urandom)}, 8'($urandom));
         send_access(mmc1_pkg::CMD_CPU_WRITE, {1'b1, sel, 13'($urandom)},
                     {1'b0, 6'($urandom), value[i]});
      end
   endtask

   task automatic random_access();
      int          r;
      logic [15:0] a;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         if ($urandom_range(0, 99) < 30)
            send_access(mmc1_pkg::CMD_CPU_WRITE, {1'b1, 15'($urandom)},
                        {1'b1, 7'($urandom)});
         load_register(mmc1_pkg::reg_sel_type'($urandom_range(0, 3)), 5'($urandom),
                       $urandom_range(0, 99) < 12);
      end else if (r < 50) begin
         send_access(mmc1_pkg::CMD_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom));
      end else if (r < 68) begin
         if ($urandom_range(0, 1)) a = 16'h6000 + 16'($urandom_range(0, 8191));
         else a = 16'h6000 + 16'($urandom_range(0, 15)) +
                  ($urandom_range(0, 1) ? 16'h1FF0 : 16'h0000);
         send_access($urandom_range(0, 1) ? mmc1_pkg::CMD_CPU_WRITE : mmc1_pkg::CMD_CPU_READ,
                     a, 8'($urandom));
      end else if (r < 88) begin
         send_access($urandom_range(0, 1) ? mmc1_pkg::CMD_PPU_WRITE : mmc1_pkg::CMD_PPU_READ,
                     {3'b000, 13'($urandom)}, 8'($urandom));
      end else begin
         send_access(mmc1_pkg::cmd_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      logic [5:0] prg_counts [PHASES];
      logic [5:0] chr_sizes [PHASES];
      int         phase_start;

      prg_counts = '{6'd1, 6'd16, 6'd0, 6'd63, 6'd7};
      chr_sizes  = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd17};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_access(mmc1_pkg::CMD_CPU_READ, 16'h8000, 8'h00);
      send_access(mmc1_pkg::CMD_CPU_READ, 16'hFFFF, 8'hFF);
      send_access(mmc1_pkg::CMD_CPU_WRITE, 16'h6000, 8'hFF);
      send_access(mmc1_pkg::CMD_CPU_READ, 16'h6000, 8'h00);
      send_access(mmc1_pkg::CMD_CPU_WRITE, 16'h7FFF, 8'h00);
      send_access(mmc1_pkg::CMD_CPU_READ, 16'h7FFF, 8'h00);
      send_access(mmc1_pkg::CMD_CPU_READ, 16'h0000, 8'h00);
      send_access(mmc1_pkg::CMD_CPU_WRITE, 16'h5FFF, 8'hA5);
      send_access(mmc1_pkg::CMD_PPU_READ, 16'h0000, 8'h00);
      send_access(mmc1_pkg::CMD_PPU_WRITE, 16'h1FFF, 8'h3C);
      send_access(mmc1_pkg::CMD_PPU_READ, 16'h2000, 8'h00);
      send_access(mmc1_pkg::CMD_PPU_WRITE, 16'hFFFF, 8'hFF);
      send_access(mmc1_pkg::CMD_CPU_WRITE, 16'h8000, 8'h80);
      load_register(mmc1_pkg::SEL_CONTROL, 5'h13, 1'b0);
      send_access(mmc1_pkg::CMD_PPU_READ, 16'h1000, 8'h00);
      send_access(mmc1_pkg::CMD_CPU_READ, 16'hC000, 8'h00);
      load_register(mmc1_pkg::SEL_PRG_BANK, 5'h1F, 1'b0);
      send_access(mmc1_pkg::CMD_CPU_WRITE, 16'hFFFF, 8'h80);
      send_access(mmc1_pkg::CMD_CPU_READ, 16'hBFFF, 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_csr(mmc1_pkg::CSR_PRG_BANK_COUNT, prg_counts[p]);
         write_csr(mmc1_pkg::CSR_CHR_SIZE_4K, chr_sizes[p]);
         write_csr(mmc1_pkg::csr_index_type'($urandom_range(2, 3)), 6'($urandom));
         settings++;
         gaps_on = (p != 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) random_access();
      end
      gaps_on = 1'b1;

      drain();
      repeat (5) @(posedge clock);
      $display("Sent %0d bus accesses across %0d CSR settings plus reset values;",
               items_sent, settings);
      $display("checked %0d result items, %0d mismatches.", shadow.checked, shadow.errors);
      if (shadow.errors == 0 && shadow.due_results.size() == 0) begin
         $display("PASS mmc1_bank_mapper");
      end else begin
         $display("FAIL mmc1_bank_mapper");
      end
      $finish;
   end

endmodule
